/* design/assert_macros.svh */
// Assertion macros shared by the mixer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define LSM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define LSM_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `LSM_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

/* design/lsm_pkg.sv */
// Shared constants, types and rounding functions of the stereo mixer.
`default_nettype none

package lsm_pkg;

  localparam int SampleW        = 16;
  localparam int GainW          = 16;
  localparam int ProdW          = 32;
  localparam int WetW           = 20;
  localparam int SumW           = 35;
  localparam int CountW         = 32;
  localparam int CfgIdxW        = 3;
  localparam int CfgDataW       = 33;
  localparam int NumLaneRegs    = 4;
  localparam int RndShift       = 14;
  localparam int DefBlockLength = 64;
  localparam int DefLaneCount   = 4;

  localparam logic [31:0] DryGainsReset = 32'h2D41_2D41;
  localparam logic [CountW-1:0] CountMax = '1;

  localparam logic signed [SumW-1:0] RoundBias = 35'sd8192;
  localparam logic signed [SumW-1:0] WetMaxS   = 35'sd524287;
  localparam logic signed [SumW-1:0] WetMinS   = -35'sd524288;
  localparam logic signed [SumW-1:0] OutMaxS   = 35'sd32767;
  localparam logic signed [SumW-1:0] OutMinS   = -35'sd32768;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_LANE_0         = 3'd0,
    CFG_LANE_1         = 3'd1,
    CFG_LANE_2         = 3'd2,
    CFG_LANE_3         = 3'd3,
    CFG_DRY_GAINS      = 3'd4,
    CFG_UNDERFLOW_MODE = 3'd5
  } cfg_idx_e;

  // Underflow behaviour codes; the unused code behaves as dry fallback.
  typedef enum logic [1:0] {
    MODE_DRY     = 2'd0,
    MODE_SILENCE = 2'd1,
    MODE_HOLD    = 2'd2
  } mode_e;

  // Per-frame control carried down the pipeline.
  typedef struct packed {
    logic usable;
    logic use_wet;
    logic silence;
    logic first;
  } ctl_t;

  // Round half up from Q.29 to Q.15 and clamp to the stored wet range.
  function automatic logic signed [WetW-1:0] wet_round_sat(input logic signed [SumW-1:0] sum);
    logic signed [SumW-1:0] t;
    t = (sum + RoundBias) >>> RndShift;
    if (t > WetMaxS) begin
      t = WetMaxS;
    end else if (t < WetMinS) begin
      t = WetMinS;
    end
    return t[WetW-1:0];
  endfunction

  // Round half up from Q.29 to Q.15 and clamp to the sample range.
  function automatic logic signed [SampleW-1:0] out_round_sat(input logic signed [SumW-1:0] sum);
    logic signed [SumW-1:0] t;
    t = (sum + RoundBias) >>> RndShift;
    if (t > OutMaxS) begin
      t = OutMaxS;
    end else if (t < OutMinS) begin
      t = OutMinS;
    end
    return t[SampleW-1:0];
  endfunction

endpackage

`default_nettype wire

/* design/lsm_in_if.sv */
// Frame input channel of the stereo mixer.
`default_nettype none

interface lsm_in_if;
  import lsm_pkg::*;

  logic                            valid;
  logic                            ready;
  logic signed [SampleW-1:0]       dry_sample;
  logic                            dry_present;
  logic signed [SampleW-1:0]       lane_sample_0;
  logic signed [SampleW-1:0]       lane_sample_1;
  logic signed [SampleW-1:0]       lane_sample_2;
  logic signed [SampleW-1:0]       lane_sample_3;
  logic [NumLaneRegs-1:0]          lane_present;
  logic                            wet_ready;

  modport source (
    output valid, dry_sample, dry_present, lane_sample_0, lane_sample_1,
           lane_sample_2, lane_sample_3, lane_present, wet_ready,
    input  ready
  );

  modport sink (
    input  valid, dry_sample, dry_present, lane_sample_0, lane_sample_1,
           lane_sample_2, lane_sample_3, lane_present, wet_ready,
    output ready
  );
endinterface

`default_nettype wire

/* design/lsm_out_if.sv */
// Stereo result channel of the mixer.
`default_nettype none

interface lsm_out_if;
  import lsm_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SampleW-1:0] out_left;
  logic signed [SampleW-1:0] out_right;
  logic [CountW-1:0]         underflow_total;

  modport source (
    output valid, out_left, out_right, underflow_total,
    input  ready
  );

  modport sink (
    input  valid, out_left, out_right, underflow_total,
    output ready
  );
endinterface

`default_nettype wire

/* design/lane_stereo_mixer.sv */
// Stereo pan mixer: dry sample plus gain-weighted wet lanes, one frame per cycle while out_o is not stalled.
// Usage:
//   Frames enter on in_i (valid/ready) and stereo results leave on out_o (valid/ready);
//   one result per frame, in order. Configuration is written through cfg_we_i,
//   cfg_idx_i and cfg_wdata_i; the user must do so only while no frame is in flight, as the block does not enforce it.
// Pipeline and throughput:
//   A result passes the lane multipliers, the lane merge with wet store read and the output
//   rounding, each registered, and can transfer once out_o is ready. One frame per cycle
//   is sustained while out_o is not stalled; the wet store takes one read and one write per cycle.
// Reset:
//   rst_ni clears the frame position, underflow count, pipeline and registers. The wet
//   store is not swept: during the first block after reset every frame writes its
//   entry (zero if its wet is unusable) and reads it as zero, so the store is usable
//   at once, with no sweep.
// Back-pressure:
//   When out_o is stalled the output register holds its result; earlier stages keep
//   filling until all three are full, and only then is in_i.ready dropped.
`default_nettype none
`include "assert_macros.svh"

module lane_stereo_mixer #(
  parameter int BLOCK_LENGTH = lsm_pkg::DefBlockLength,
  parameter int LANE_COUNT   = lsm_pkg::DefLaneCount
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [lsm_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [lsm_pkg::CfgDataW-1:0]    cfg_wdata_i,
  lsm_in_if.sink                               in_i,
  lsm_out_if.source                            out_o
);
  import lsm_pkg::*;

  localparam int PosW = (BLOCK_LENGTH > 1) ? $clog2(BLOCK_LENGTH) : 1;
  localparam logic [PosW-1:0] PosLast = PosW'(BLOCK_LENGTH - 1);
  localparam int RamW = 2 * WetW;

  // Configuration registers
  logic [CfgDataW-1:0] lane_setup_q [LANE_COUNT];
  logic [31:0]         dry_gains_q;
  logic [1:0]          mode_q;

  // Input-side state
  logic [PosW-1:0]   pos_q;
  logic              first_q;
  logic [CountW-1:0] cnt_q;
  logic [CountW-1:0] cnt_d;

  // Handshake
  logic acc;
  logic s1_rdy, s2_rdy, out_adv;
  logic s1_mv, s2_mv;

  // Stage 1
  logic              s1_vld_q;
  ctl_t              s1_ctl_q;
  logic [PosW-1:0]   s1_pos_q;
  logic [CountW-1:0] s1_cnt_q;

  // Stage 2
  logic                    s2_vld_q;
  ctl_t                    s2_ctl_q;
  logic [PosW-1:0]         s2_pos_q;
  logic [CountW-1:0]       s2_cnt_q;
  logic signed [WetW-1:0]  s2_wet_l_q, s2_wet_r_q;
  logic signed [ProdW-1:0] s2_dry_l_q, s2_dry_r_q;
  logic                    s2_fwd_q;
  logic [RamW-1:0]         s2_fwd_data_q;

  // Output register
  logic                      out_vld_q;
  logic signed [SampleW-1:0] out_left_q, out_right_q;
  logic [CountW-1:0]         out_cnt_q;

  // Lane signals
  logic signed [SampleW-1:0] smp [NumLaneRegs];
  logic [LANE_COUNT-1:0]     lane_en;
  logic signed [ProdW-1:0]   prod_l [LANE_COUNT];
  logic signed [ProdW-1:0]   prod_r [LANE_COUNT];
  logic signed [ProdW-1:0]   dry_l, dry_r;
  logic signed [WetW-1:0]    wet_l, wet_r;
  logic                      usable;
  ctl_t                      ctl_in;

  // Wet store signals
  logic            ram_we, ram_re;
  logic [RamW-1:0] ram_wdata, ram_rdata;
  logic [RamW-1:0] held;
  logic signed [WetW-1:0] wsel_l, wsel_r;
  logic signed [SumW-1:0] mix_l, mix_r;

  // Register writes; indexes of absent lanes and beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LANE_COUNT; k++) begin
        lane_setup_q[k] <= '0;
      end
      dry_gains_q <= DryGainsReset;
      mode_q      <= MODE_DRY;
    end else if (cfg_we_i) begin
      for (int k = 0; k < LANE_COUNT; k++) begin
        if (cfg_idx_i == CfgIdxW'(k)) begin
          lane_setup_q[k] <= cfg_wdata_i;
        end
      end
      if (cfg_idx_i == CFG_DRY_GAINS) begin
        dry_gains_q <= cfg_wdata_i[31:0];
      end
      if (cfg_idx_i == CFG_UNDERFLOW_MODE) begin
        mode_q <= cfg_wdata_i[1:0];
      end
    end
  end

  // Pipeline handshake: each stage moves when the next one is empty or moving.
  assign out_adv    = !out_vld_q || out_o.ready;
  assign s2_rdy     = !s2_vld_q || out_adv;
  assign s2_mv      = s2_vld_q && out_adv;
  assign s1_rdy     = !s1_vld_q || s2_rdy;
  assign s1_mv      = s1_vld_q && s2_rdy;
  assign in_i.ready = s1_rdy;
  assign acc        = in_i.valid && s1_rdy;

  // Wet usability: ready, and every enabled lane present.
  assign smp[0] = in_i.lane_sample_0;
  assign smp[1] = in_i.lane_sample_1;
  assign smp[2] = in_i.lane_sample_2;
  assign smp[3] = in_i.lane_sample_3;

  always_comb begin
    for (int k = 0; k < LANE_COUNT; k++) begin
      lane_en[k] = lane_setup_q[k][CfgDataW-1];
    end
  end

  assign usable = in_i.wet_ready && (&(~lane_en | in_i.lane_present[LANE_COUNT-1:0]));

  always_comb begin
    ctl_in.usable  = usable;
    ctl_in.use_wet = usable || (mode_q == MODE_HOLD);
    ctl_in.silence = !usable && (mode_q == MODE_SILENCE);
    ctl_in.first   = first_q;
  end

  // Underflow counts only on the first frame of a block, saturating.
  always_comb begin
    cnt_d = cnt_q;
    if (!usable && (pos_q == '0) && (cnt_q != CountMax)) begin
      cnt_d = cnt_q + CountW'(1);
    end
  end

  // Frame position, first-block flag and underflow count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      first_q <= 1'b1;
      cnt_q   <= '0;
    end else if (acc) begin
      cnt_q <= cnt_d;
      if (pos_q == PosLast) begin
        pos_q   <= '0;
        first_q <= 1'b0;
      end else begin
        pos_q <= pos_q + PosW'(1);
      end
    end
  end

  // Lane multipliers, one copy per lane, plus one for the dry path.
  for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
    lsm_lane u_lane (
      .clk_i    (clk_i),
      .load_i   (acc),
      .en_i     (lane_en[g]),
      .sample_i (smp[g]),
      .gains_i  (lane_setup_q[g][2*GainW-1:0]),
      .prod_l_o (prod_l[g]),
      .prod_r_o (prod_r[g])
    );
  end

  lsm_lane u_dry (
    .clk_i    (clk_i),
    .load_i   (acc),
    .en_i     (in_i.dry_present),
    .sample_i (in_i.dry_sample),
    .gains_i  (dry_gains_q),
    .prod_l_o (dry_l),
    .prod_r_o (dry_r)
  );

  // Stage 1 control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (s1_rdy) begin
      s1_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_ctl_q <= ctl_in;
      s1_pos_q <= pos_q;
      s1_cnt_q <= cnt_d;
    end
  end

  // Merge the lane products into the wet pair.
  lsm_merge #(
    .LaneCount (LANE_COUNT)
  ) u_merge (
    .prod_l_i (prod_l),
    .prod_r_i (prod_r),
    .wet_l_o  (wet_l),
    .wet_r_o  (wet_r)
  );

  // Wet store: read as a frame enters stage 2, written as it leaves. In the first
  // block an unusable frame writes zero so that every entry is defined afterwards.
  assign ram_re    = s1_mv;
  assign ram_we    = s2_mv && (s2_ctl_q.usable || s2_ctl_q.first);
  assign ram_wdata = s2_ctl_q.usable ? {s2_wet_l_q, s2_wet_r_q} : '0;

  lsm_ram #(
    .Width (RamW),
    .Depth (BLOCK_LENGTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s2_pos_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (s1_pos_q),
    .rdata_o (ram_rdata)
  );

  // Stage 2 control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (s2_rdy) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  // Stage 2 payload; a write to the same entry in the read cycle is forwarded.
  always_ff @(posedge clk_i) begin
    if (s1_mv) begin
      s2_ctl_q      <= s1_ctl_q;
      s2_pos_q      <= s1_pos_q;
      s2_cnt_q      <= s1_cnt_q;
      s2_wet_l_q    <= wet_l;
      s2_wet_r_q    <= wet_r;
      s2_dry_l_q    <= dry_l;
      s2_dry_r_q    <= dry_r;
      s2_fwd_q      <= ram_we && (s2_pos_q == s1_pos_q);
      s2_fwd_data_q <= ram_wdata;
    end
  end

  // Wet chosen for the output: fresh, held, or none.
  always_comb begin
    if (s2_ctl_q.first) begin
      held = '0;
    end else if (s2_fwd_q) begin
      held = s2_fwd_data_q;
    end else begin
      held = ram_rdata;
    end
    if (s2_ctl_q.usable) begin
      wsel_l = s2_wet_l_q;
      wsel_r = s2_wet_r_q;
    end else if (s2_ctl_q.use_wet) begin
      wsel_l = held[RamW-1:WetW];
      wsel_r = held[WetW-1:0];
    end else begin
      wsel_l = '0;
      wsel_r = '0;
    end
    mix_l = SumW'(s2_dry_l_q) + (SumW'(wsel_l) <<< RndShift);
    mix_r = SumW'(s2_dry_r_q) + (SumW'(wsel_r) <<< RndShift);
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_adv) begin
      out_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_mv) begin
      out_left_q  <= s2_ctl_q.silence ? '0 : out_round_sat(mix_l);
      out_right_q <= s2_ctl_q.silence ? '0 : out_round_sat(mix_r);
      out_cnt_q   <= s2_cnt_q;
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.out_left        = out_left_q;
  assign out_o.out_right       = out_right_q;
  assign out_o.underflow_total = out_cnt_q;

  // Checks on position, count and store control.
  `LSM_ASSERT(a_pos_wrap, clk_i, rst_ni, (acc && (pos_q == PosLast)) |=> (pos_q == '0), "frame position did not wrap after the last frame")
  `LSM_ASSERT(a_cnt_step, clk_i, rst_ni, (cnt_q != $past(cnt_q)) |-> (cnt_q == $past(cnt_q) + 32'd1), "underflow count moved by other than one")
  `LSM_ASSERT_NEVER(a_we_empty, clk_i, rst_ni, ram_we && !s2_vld_q, "wet store written with stage 2 empty")
  `LSM_ASSERT(a_first_end, clk_i, rst_ni, $fell(first_q) |-> (pos_q == '0), "first block ended away from position zero")

endmodule

`default_nettype wire

/* design/lsm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lsm_ram #(
  parameter int Width = 40,
  parameter int Depth = 64
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                           wdata_i,
  input  wire logic                                       re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output      logic [Width-1:0]                           rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port; a read at a written address sees the old word.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* design/lsm_lane.sv */
// One multiply lane: a sample scaled by a left and a right gain, registered.
`default_nettype none

module lsm_lane (
  input  wire logic                               clk_i,
  input  wire logic                               load_i,
  input  wire logic                               en_i,
  input  wire logic signed [lsm_pkg::SampleW-1:0] sample_i,
  input  wire logic [2*lsm_pkg::GainW-1:0]        gains_i,
  output      logic signed [lsm_pkg::ProdW-1:0]   prod_l_o,
  output      logic signed [lsm_pkg::ProdW-1:0]   prod_r_o
);
  import lsm_pkg::*;

  logic signed [GainW-1:0] gain_l;
  logic signed [GainW-1:0] gain_r;
  logic signed [ProdW-1:0] prod_l_q;
  logic signed [ProdW-1:0] prod_r_q;

  assign gain_l = gains_i[2*GainW-1:GainW];
  assign gain_r = gains_i[GainW-1:0];

  // A disabled lane contributes nothing to the sums.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      if (en_i) begin
        prod_l_q <= sample_i * gain_l;
        prod_r_q <= sample_i * gain_r;
      end else begin
        prod_l_q <= '0;
        prod_r_q <= '0;
      end
    end
  end

  assign prod_l_o = prod_l_q;
  assign prod_r_o = prod_r_q;

endmodule

`default_nettype wire

/* design/lsm_merge.sv */
// Merging stage: adds the lane products and rounds them to the stored wet format.
`default_nettype none

module lsm_merge #(
  parameter int LaneCount = lsm_pkg::DefLaneCount
) (
  input  wire logic signed [lsm_pkg::ProdW-1:0] prod_l_i [LaneCount],
  input  wire logic signed [lsm_pkg::ProdW-1:0] prod_r_i [LaneCount],
  output      logic signed [lsm_pkg::WetW-1:0]  wet_l_o,
  output      logic signed [lsm_pkg::WetW-1:0]  wet_r_o
);
  import lsm_pkg::*;

  logic signed [SumW-1:0] sum_l;
  logic signed [SumW-1:0] sum_r;

  // Exact sum over the lanes, then round and clamp.
  always_comb begin
    sum_l = '0;
    sum_r = '0;
    for (int k = 0; k < LaneCount; k++) begin
      sum_l = sum_l + SumW'(prod_l_i[k]);
      sum_r = sum_r + SumW'(prod_r_i[k]);
    end
  end

  assign wet_l_o = wet_round_sat(sum_l);
  assign wet_r_o = wet_round_sat(sum_r);

endmodule

`default_nettype wire

/* tb/tb_lane_stereo_mixer.sv */
// Self-checking testbench for the lane stereo mixer, with a local mixing model.
`timescale 1ns / 1ps

module tb_lane_stereo_mixer;
  import lsm_pkg::*;

  localparam int BlockLength = DefBlockLength;
  localparam int LaneCount   = DefLaneCount;
  localparam int CycleLimit  = 200000;
  localparam int ReportLimit = 200;
  localparam int PhaseFrames = 80;
  localparam int RandomPhases = 8;

  // Register indexes past the end of the map; writes to them must be dropped.
  localparam logic [CfgIdxW-1:0] CFG_UNMAPPED_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_UNMAPPED_HI = 3'd7;
  // Spare underflow code, which falls back to dry only.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic signed [SampleW-1:0]           dry;
    logic                                dry_present;
    logic [NumLaneRegs-1:0][SampleW-1:0] lane;
    logic [NumLaneRegs-1:0]              present;
    logic                                wet_ready;
  } frame_t;

  typedef struct packed {
    logic signed [SampleW-1:0] left;
    logic signed [SampleW-1:0] right;
    logic [CountW-1:0]         total;
  } mix_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_wdata_i;

  lsm_in_if  frame_bus ();
  lsm_out_if mix_bus ();

  lane_stereo_mixer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (frame_bus),
    .out_o       (mix_bus)
  );

  // Local copy of the mixer's registers and state.
  logic [CfgDataW-1:0]  lane_word [NumLaneRegs];
  logic [31:0]          dry_word;
  logic [1:0]           fallback_mode;
  logic signed [WetW-1:0] stored_left  [BlockLength];
  logic signed [WetW-1:0] stored_right [BlockLength];
  int unsigned          frame_pos;
  logic [CountW-1:0]    underflow_seen;

  frame_t frames_to_send [$];
  mix_t   expected_mix [$];

  int errors    = 0;
  int cycles    = 0;
  int send_odds = 0;
  int recv_odds = 0;
  int send_gap  = 0;
  int recv_gap  = 0;

  // Clock with a 2 ns period.
  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Round half up from Q.29 to Q.15 by a floor shift.
  function automatic longint round_q15(input longint v);
    return (v + 64'sd8192) >>> RndShift;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    if (v < lo) begin
      return lo;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  task automatic model_reset();
    for (int k = 0; k < NumLaneRegs; k++) begin
      lane_word[k] = '0;
    end
    dry_word      = DryGainsReset;
    fallback_mode = MODE_DRY;
    for (int i = 0; i < BlockLength; i++) begin
      stored_left[i]  = '0;
      stored_right[i] = '0;
    end
    frame_pos      = 0;
    underflow_seen = '0;
  endtask

  task automatic apply_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    case (idx)
      CFG_LANE_0, CFG_LANE_1, CFG_LANE_2, CFG_LANE_3: begin
        lane_word[idx] = data;
      end
      CFG_DRY_GAINS: begin
        dry_word = data[31:0];
      end
      CFG_UNDERFLOW_MODE: begin
        fallback_mode = data[1:0];
      end
      default: begin
      end
    endcase
  endtask

  // Mix one accepted frame into the model and queue the stereo result it must give.
  task automatic mix_frame(input frame_t f);
    logic        usable;
    logic        use_wet;
    longint      acc_l;
    longint      acc_r;
    longint      smp;
    longint      dry;
    longint      wl;
    longint      wr;
    longint      gl;
    longint      gr;
    int unsigned pos;
    mix_t        res;
    pos    = frame_pos;
    usable = f.wet_ready;
    acc_l  = 0;
    acc_r  = 0;
    for (int k = 0; k < LaneCount; k++) begin
      if (lane_word[k][32]) begin
        if (!f.present[k]) begin
          usable = 1'b0;
        end
        smp   = longint'($signed(f.lane[k]));
        acc_l += smp * longint'($signed(lane_word[k][31:16]));
        acc_r += smp * longint'($signed(lane_word[k][15:0]));
      end
    end

    // A usable frame refreshes the stored wet; otherwise the first frame counts an underflow.
    if (usable) begin
      stored_left[pos]  = WetW'(clamp(round_q15(acc_l), -524288, 524287));
      stored_right[pos] = WetW'(clamp(round_q15(acc_r), -524288, 524287));
    end else if (pos == 0 && underflow_seen != CountMax) begin
      underflow_seen++;
    end
    res.total = underflow_seen;

    if (!usable && fallback_mode == MODE_SILENCE) begin
      res.left  = '0;
      res.right = '0;
    end else begin
      use_wet   = usable || fallback_mode == MODE_HOLD;
      dry       = f.dry_present ? longint'($signed(f.dry)) : 0;
      wl        = use_wet ? longint'(stored_left[pos]) : 0;
      wr        = use_wet ? longint'(stored_right[pos]) : 0;
      gl        = longint'($signed(dry_word[31:16]));
      gr        = longint'($signed(dry_word[15:0]));
      res.left  = SampleW'(clamp(round_q15(dry * gl + wl * 16384), -32768, 32767));
      res.right = SampleW'(clamp(round_q15(dry * gr + wr * 16384), -32768, 32767));
    end

    frame_pos = (pos == BlockLength - 1) ? 0 : pos + 1;
    expected_mix.push_back(res);
  endtask

  // Compare one result transfer with the oldest expected result.
  task automatic check_mix();
    mix_t want;
    if (expected_mix.size() == 0) begin
      errors++;
      if (errors <= ReportLimit) begin
        $display("%0t: unexpected result, expected none, actual %0d %0d %0d", $time,
                 $signed(mix_bus.out_left), $signed(mix_bus.out_right), mix_bus.underflow_total);
      end
      return;
    end
    want = expected_mix.pop_front();
    if (mix_bus.out_left !== want.left) begin
      errors++;
      if (errors <= ReportLimit) begin
        $display("%0t: out_left expected %0d actual %0d", $time,
                 $signed(want.left), $signed(mix_bus.out_left));
      end
    end
    if (mix_bus.out_right !== want.right) begin
      errors++;
      if (errors <= ReportLimit) begin
        $display("%0t: out_right expected %0d actual %0d", $time,
                 $signed(want.right), $signed(mix_bus.out_right));
      end
    end
    if (mix_bus.underflow_total !== want.total) begin
      errors++;
      if (errors <= ReportLimit) begin
        $display("%0t: underflow_total expected %0d actual %0d", $time,
                 want.total, mix_bus.underflow_total);
      end
    end
  endtask

  // Frame driver: presents the head of the queue and holds it until its transfer.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      frame_bus.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (frame_bus.valid && frame_bus.ready) begin
        mix_frame(frames_to_send.pop_front());
        if (send_odds != 0 && $urandom_range(1, send_odds) == 1) begin
          send_gap = $urandom_range(1, 17);
        end
      end
      if (frame_bus.valid && !frame_bus.ready) begin
        // Stalled: keep the same frame on the bus.
      end else if (send_gap > 0) begin
        frame_bus.valid <= 1'b0;
        send_gap--;
      end else if (frames_to_send.size() != 0) begin
        frame_bus.valid         <= 1'b1;
        frame_bus.dry_sample    <= frames_to_send[0].dry;
        frame_bus.dry_present   <= frames_to_send[0].dry_present;
        frame_bus.lane_sample_0 <= frames_to_send[0].lane[0];
        frame_bus.lane_sample_1 <= frames_to_send[0].lane[1];
        frame_bus.lane_sample_2 <= frames_to_send[0].lane[2];
        frame_bus.lane_sample_3 <= frames_to_send[0].lane[3];
        frame_bus.lane_present  <= frames_to_send[0].present;
        frame_bus.wet_ready     <= frames_to_send[0].wet_ready;
      end else begin
        frame_bus.valid <= 1'b0;
      end
    end
  end

  // Result monitor: checks each transfer and stalls in random bursts.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      mix_bus.ready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (mix_bus.valid && mix_bus.ready) begin
        check_mix();
      end
      if (recv_gap > 0) begin
        mix_bus.ready <= 1'b0;
        recv_gap--;
      end else if (recv_odds != 0 && $urandom_range(1, recv_odds * 4) == 1) begin
        mix_bus.ready <= 1'b0;
        recv_gap = $urandom_range(0, 16);
      end else begin
        mix_bus.ready <= 1'b1;
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Timed out after %0d cycles with %0d results outstanding", cycles,
               expected_mix.size());
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [SampleW-1:0] pick_sample();
    case ($urandom_range(0, 11))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [GainW-1:0] pick_gain();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return 16'h4000;
      3:       return 16'hC000;
      4:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [1:0] pick_mode();
    case ($urandom_range(0, 3))
      0:       return MODE_DRY;
      1:       return MODE_SILENCE;
      2:       return MODE_HOLD;
      default: return MODE_SPARE;
    endcase
  endfunction

  // A well-formed frame has its wet ready and every enabled lane present.
  function automatic frame_t random_frame(input bit well_formed);
    frame_t f;
    logic [NumLaneRegs-1:0] enabled;
    for (int k = 0; k < NumLaneRegs; k++) begin
      enabled[k] = lane_word[k][32];
      f.lane[k]  = pick_sample();
    end
    f.dry         = pick_sample();
    f.dry_present = ($urandom_range(0, 7) != 0);
    if (well_formed) begin
      f.present   = enabled | 4'($urandom);
      f.wet_ready = 1'b1;
    end else begin
      f.present   = 4'($urandom);
      f.wet_ready = 1'($urandom);
    end
    return f;
  endfunction

  task automatic queue_frame(input logic [SampleW-1:0] dry, input logic dry_on,
                             input logic [SampleW-1:0] lane_val,
                             input logic [NumLaneRegs-1:0] present, input logic ready);
    frame_t f;
    f.dry         = dry;
    f.dry_present = dry_on;
    for (int k = 0; k < NumLaneRegs; k++) begin
      f.lane[k] = lane_val;
    end
    f.present   = present;
    f.wet_ready = ready;
    frames_to_send.push_back(f);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    apply_reg(idx, data);
  endtask

  // Wait until every frame has been sent and every result has come back.
  task automatic drain();
    while (frames_to_send.size() != 0 || expected_mix.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  // New random setting; the spare bits of narrow registers carry noise.
  task automatic random_setup();
    logic [CfgDataW-1:0] junk;
    for (int k = 0; k < NumLaneRegs; k++) begin
      write_reg(CfgIdxW'(k), {($urandom_range(0, 3) != 0), pick_gain(), pick_gain()});
    end
    junk = CfgDataW'({$urandom, $urandom});
    write_reg(CFG_DRY_GAINS, {junk[32], pick_gain(), pick_gain()});
    write_reg(CFG_UNDERFLOW_MODE, {junk[32:2], pick_mode()});
    if ($urandom_range(0, 2) == 0) begin
      write_reg($urandom_range(0, 1) ? CFG_UNMAPPED_LO : CFG_UNMAPPED_HI, junk);
    end
  endtask

  // Stimulus and end of run.
  initial begin
    frame_t f;
    int     wf_pct;
    int     odds_pick;
    rst_ni                  = 1'b0;
    cfg_we_i                = 1'b0;
    cfg_idx_i               = CFG_LANE_0;
    cfg_wdata_i             = '0;
    frame_bus.valid         = 1'b0;
    frame_bus.dry_sample    = '0;
    frame_bus.dry_present   = 1'b0;
    frame_bus.lane_sample_0 = '0;
    frame_bus.lane_sample_1 = '0;
    frame_bus.lane_sample_2 = '0;
    frame_bus.lane_sample_3 = '0;
    frame_bus.lane_present  = '0;
    frame_bus.wet_ready     = 1'b0;
    mix_bus.ready           = 1'b0;
    model_reset();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset setting: no lanes enabled, so the wet hangs on wet_ready alone.
    queue_frame(16'h7FFF, 1'b1, 16'h0000, 4'h0, 1'b0);
    queue_frame(16'h8000, 1'b1, 16'h7FFF, 4'hF, 1'b1);
    queue_frame(16'h7FFF, 1'b0, 16'h8000, 4'h0, 1'b1);
    queue_frame(16'hFFFF, 1'b1, 16'h8000, 4'h5, 1'b0);
    drain();

    // Every lane on with extreme gains, hold mode, and a dropped write past the map.
    write_reg(CFG_LANE_0, {1'b1, 16'h8000, 16'h7FFF});
    write_reg(CFG_LANE_1, {1'b1, 16'h8000, 16'h8000});
    write_reg(CFG_LANE_2, {1'b1, 16'h7FFF, 16'h7FFF});
    write_reg(CFG_LANE_3, {1'b1, 16'h7FFF, 16'h8000});
    write_reg(CFG_DRY_GAINS, {1'b1, 16'h7FFF, 16'h8000});
    write_reg(CFG_UNDERFLOW_MODE, {31'h0, MODE_HOLD});
    write_reg(CFG_UNMAPPED_HI, '1);
    queue_frame(16'h7FFF, 1'b1, 16'h8000, 4'hF, 1'b1);
    queue_frame(16'h8000, 1'b1, 16'h7FFF, 4'hF, 1'b1);
    queue_frame(16'h8000, 1'b1, 16'h8000, 4'hF, 1'b1);
    f = random_frame(1'b1);
    f.lane[2] = 16'h7FFF;
    f.lane[0] = 16'h8000;
    frames_to_send.push_back(f);
    queue_frame(16'h7FFF, 1'b1, 16'h7FFF, 4'hE, 1'b1);
    queue_frame(16'h4000, 1'b1, 16'h8000, 4'hF, 1'b0);
    queue_frame(16'h8000, 1'b0, 16'h7FFF, 4'h7, 1'b1);
    drain();

    // Silence on underflow.
    write_reg(CFG_UNDERFLOW_MODE, {31'h0, MODE_SILENCE});
    queue_frame(16'h7FFF, 1'b1, 16'h1234, 4'h0, 1'b1);
    queue_frame(16'h8000, 1'b1, 16'h8000, 4'hF, 1'b0);
    queue_frame(16'h7FFF, 1'b1, 16'h7FFF, 4'hF, 1'b1);
    drain();

    // Spare mode code, and a dropped write to the lower unmapped index.
    write_reg(CFG_UNDERFLOW_MODE, {31'h7FFF_FFFF, MODE_SPARE});
    write_reg(CFG_UNMAPPED_LO, '1);
    queue_frame(16'h7FFF, 1'b1, 16'h7FFF, 4'hB, 1'b1);
    queue_frame(16'h8000, 1'b1, 16'h8000, 4'hF, 1'b0);
    queue_frame(16'h0001, 1'b1, 16'hFFFF, 4'hF, 1'b1);
    drain();

    // Random phases, each under a fresh setting; the last one runs without idling.
    for (int phase = 0; phase < RandomPhases; phase++) begin
      drain();
      random_setup();
      if (phase == RandomPhases - 1) begin
        send_odds = 0;
        recv_odds = 0;
      end else begin
        odds_pick = $urandom_range(0, 3);
        send_odds = (odds_pick == 0) ? 0 : odds_pick * 4;
        odds_pick = $urandom_range(0, 3);
        recv_odds = (odds_pick == 0) ? 0 : odds_pick * 2;
      end
      wf_pct = $urandom_range(60, 95);
      for (int i = 0; i < PhaseFrames; i++) begin
        frames_to_send.push_back(random_frame($urandom_range(1, 100) <= wf_pct));
      end
    end

    drain();
    repeat (6) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
